// File: rtl/core/salt_pkg.sv
`default_nettype none

package salt_pkg;

  // Geometry of the tag store
  localparam int SETS   = 64;
  localparam int WAYS   = 4;
  localparam int ADDR_W = 16;

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NW_W   = $clog2(WAYS + 1);
  localparam int SB_MAX = (SET_W < 6) ? SET_W : 6;

  // Fixed field widths of the beats
  localparam int TAG_W     = 16;
  localparam int SETOUT_W  = 6;
  localparam int WAYOUT_W  = 2;
  localparam int CNT_W     = 32;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // Configuration register indexes
  localparam logic [1:0] REG_ADDR_BITS = 2'd0;
  localparam logic [1:0] REG_SET_BITS  = 2'd1;
  localparam logic [1:0] REG_WAYS      = 2'd2;

  // One memory row holds a whole set
  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0][WAY_W-1:0] rank;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // Lookup decision handed back to the control logic
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    row_t             row;
  } sel_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_e;

  // Row contents of a set that was never written: empty, rank equals way
  function automatic row_t reset_row(input logic [WAYS-1:0][TAG_W-1:0] tags);
    row_t r;
    r.tag   = tags;
    r.valid = '0;
    for (int w = 0; w < WAYS; w++) begin
      r.rank[w] = WAY_W'(w);
    end
    return r;
  endfunction

  function automatic logic [2:0] eff_set_bits(input logic [2:0] sb);
    return (sb > 3'(SB_MAX)) ? 3'(SB_MAX) : sb;
  endfunction

  function automatic logic [NW_W-1:0] eff_ways(input logic [2:0] nw);
    logic [NW_W-1:0] res;
    if (nw == 3'd0) begin
      res = NW_W'(1);
    end else if (32'(nw) > 32'(WAYS)) begin
      res = NW_W'(WAYS);
    end else begin
      res = NW_W'(nw);
    end
    return res;
  endfunction

  function automatic logic [SET_W-1:0] set_of(input logic [ADDR_W-1:0] addr,
                                              input logic [2:0] sb);
    logic [ADDR_W-1:0] mask;
    mask = ~({ADDR_W{1'b1}} << sb);
    return SET_W'(addr & mask);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/salt_ram.sv
`default_nettype none

module salt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic                                          re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                                   rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/salt_way_sel.sv
`default_nettype none

module salt_way_sel (
  input  wire salt_pkg::row_t                  row_i,
  input  wire logic [salt_pkg::TAG_W-1:0]      tag_i,
  input  wire logic [salt_pkg::NW_W-1:0]       nw_i,
  output salt_pkg::sel_t                       sel_o
);

  logic                             found_hit;
  logic                             found_empty;
  logic [salt_pkg::WAY_W-1:0]       hit_way;
  logic [salt_pkg::WAY_W-1:0]       empty_way;
  logic [salt_pkg::WAY_W-1:0]       lru_way;
  logic [salt_pkg::WAY_W-1:0]       best;
  logic [salt_pkg::WAY_W-1:0]       way;
  logic [salt_pkg::WAY_W-1:0]       old_rank;
  salt_pkg::row_t                   nrow;

  // Compare tags, find the first empty way and the least recent way in use
  always_comb begin
    found_hit   = 1'b0;
    found_empty = 1'b0;
    hit_way     = '0;
    empty_way   = '0;
    lru_way     = '0;
    best        = '0;
    // walk downward so the lowest-numbered way wins
    for (int w = salt_pkg::WAYS - 1; w >= 0; w--) begin
      if (w < int'(nw_i)) begin
        if (row_i.valid[w] && (row_i.tag[w] == tag_i)) begin
          found_hit = 1'b1;
          hit_way   = salt_pkg::WAY_W'(w);
        end
        if (!row_i.valid[w]) begin
          found_empty = 1'b1;
          empty_way   = salt_pkg::WAY_W'(w);
        end
      end
    end
    for (int w = 0; w < salt_pkg::WAYS; w++) begin
      if ((w < int'(nw_i)) && (row_i.rank[w] >= best)) begin
        best    = row_i.rank[w];
        lru_way = salt_pkg::WAY_W'(w);
      end
    end
  end

  // Pick the way, refill it on a miss and make it most recent
  always_comb begin
    if (found_hit) begin
      way = hit_way;
    end else if (found_empty) begin
      way = empty_way;
    end else begin
      way = lru_way;
    end
    nrow     = row_i;
    old_rank = row_i.rank[way];
    for (int w = 0; w < salt_pkg::WAYS; w++) begin
      if (row_i.rank[w] < old_rank) begin
        nrow.rank[w] = row_i.rank[w] + salt_pkg::WAY_W'(1);
      end
    end
    nrow.rank[way] = '0;
    if (!found_hit) begin
      nrow.tag[way]   = tag_i;
      nrow.valid[way] = 1'b1;
    end
  end

  assign sel_o.hit = found_hit;
  assign sel_o.way = way;
  assign sel_o.row = nrow;

endmodule

`default_nettype wire

// File: rtl/core/set_assoc_lru_tag_lookup_core.sv
// Lookup: the set is read at the edge that accepts an address beat; compare, replacement
// and write-back happen in ST_LOOK, which ends by registering the result beat once the
// result register is free. No new address is taken while a lookup is in progress, so a
// stalled result holds off the next lookup.
// Reset: configuration returns to 16 address bits, 4 set bits, 4 ways; counts clear;
// per-set valid flops make every set read as empty at once, with no clearing pass.
`default_nettype none

module set_assoc_lru_tag_lookup_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // address channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [salt_pkg::ADDR_W-1:0]     in_address_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 out_hit_o,
  output logic                                 out_out_of_range_o,
  output logic [salt_pkg::SETOUT_W-1:0]        out_set_index_o,
  output logic [salt_pkg::TAG_W-1:0]           out_tag_value_o,
  output logic [salt_pkg::WAYOUT_W-1:0]        out_way_used_o,
  output logic [salt_pkg::CNT_W-1:0]           out_hit_total_o,
  output logic [salt_pkg::CNT_W-1:0]           out_access_total_o,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [salt_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [salt_pkg::PDATA_W-1:0]    pwdata,
  output logic [salt_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);

  salt_pkg::state_e                  state_q, state_d;
  logic [4:0]                        addr_bits_q;
  logic [2:0]                        set_bits_q;
  logic [2:0]                        ways_q;
  logic [salt_pkg::ADDR_W-1:0]       addr_q;
  logic [salt_pkg::SETS-1:0]         rowv_q;
  logic [salt_pkg::CNT_W-1:0]        hit_cnt_q, acc_cnt_q;
  logic                              out_valid_q;
  logic                              out_hit_q, out_oor_q;
  logic [salt_pkg::SETOUT_W-1:0]     out_set_q;
  logic [salt_pkg::TAG_W-1:0]        out_tag_q;
  logic [salt_pkg::WAYOUT_W-1:0]     out_way_q;

  logic                              in_acc;
  logic                              cfg_wr;
  logic                              look_done;
  logic                              mem_we;
  logic [2:0]                        sb;
  logic [4:0]                        aw;
  logic                              oor;
  logic [salt_pkg::SET_W-1:0]        rd_set;
  logic [salt_pkg::SET_W-1:0]        look_set;
  logic [salt_pkg::TAG_W-1:0]        look_tag;
  logic [salt_pkg::ROW_W-1:0]        rdata;
  salt_pkg::row_t                    mem_row;
  salt_pkg::row_t                    cur_row;
  salt_pkg::sel_t                    sel;

  // Handshakes
  assign in_stall_o = (state_q != salt_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_bits_q <= 5'd16;
      set_bits_q  <= 3'd4;
      ways_q      <= 3'd4;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        salt_pkg::REG_ADDR_BITS: addr_bits_q <= pwdata[4:0];
        salt_pkg::REG_SET_BITS:  set_bits_q  <= pwdata[2:0];
        salt_pkg::REG_WAYS:      ways_q      <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[3:2])
      salt_pkg::REG_ADDR_BITS: prdata = salt_pkg::PDATA_W'(addr_bits_q);
      salt_pkg::REG_SET_BITS:  prdata = salt_pkg::PDATA_W'(set_bits_q);
      salt_pkg::REG_WAYS:      prdata = salt_pkg::PDATA_W'(ways_q);
      default:                 prdata = '0;
    endcase
  end

  // Decode the address against the configured geometry
  assign sb       = salt_pkg::eff_set_bits(set_bits_q);
  assign rd_set   = salt_pkg::set_of(in_address_i, sb);
  assign look_set = salt_pkg::set_of(addr_q, sb);
  assign look_tag = salt_pkg::TAG_W'(addr_q >> sb);
  assign aw       = (addr_bits_q > 5'(salt_pkg::ADDR_W)) ? 5'(salt_pkg::ADDR_W) : addr_bits_q;
  assign oor      = ((addr_q >> aw) != '0);

  // Set memory: one row per set
  salt_ram #(
    .WIDTH (salt_pkg::ROW_W),
    .DEPTH (salt_pkg::SETS)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (look_set),
    .wdata_i (sel.row),
    .re_i    (in_acc),
    .raddr_i (rd_set),
    .rdata_o (rdata)
  );

  // A never-written set reads as empty with reset ranks
  assign mem_row = salt_pkg::row_t'(rdata);
  assign cur_row = rowv_q[look_set] ? mem_row : salt_pkg::reset_row(mem_row.tag);

  salt_way_sel u_way_sel (
    .row_i (cur_row),
    .tag_i (look_tag),
    .nw_i  (salt_pkg::eff_ways(ways_q)),
    .sel_o (sel)
  );

  // Finish the lookup once the result register is free
  assign look_done = (state_q == salt_pkg::ST_LOOK) && (!out_valid_q || !out_stall_i);
  assign mem_we    = look_done && !oor;

  always_comb begin
    state_d = state_q;
    case (state_q)
      salt_pkg::ST_IDLE: if (in_acc) state_d = salt_pkg::ST_LOOK;
      salt_pkg::ST_LOOK: if (look_done) state_d = salt_pkg::ST_IDLE;
      default:           state_d = salt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= salt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the address for the lookup
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      addr_q <= in_address_i;
    end
  end

  // Mark written sets and advance the saturating counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rowv_q    <= '0;
      hit_cnt_q <= '0;
      acc_cnt_q <= '0;
    end else if (mem_we) begin
      rowv_q[look_set] <= 1'b1;
      if (sel.hit && (hit_cnt_q != '1)) begin
        hit_cnt_q <= hit_cnt_q + salt_pkg::CNT_W'(1);
      end
      if (acc_cnt_q != '1) begin
        acc_cnt_q <= acc_cnt_q + salt_pkg::CNT_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (look_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (look_done) begin
      out_oor_q <= oor;
      if (oor) begin
        out_hit_q <= 1'b0;
        out_set_q <= '0;
        out_tag_q <= '0;
        out_way_q <= '0;
      end else begin
        out_hit_q <= sel.hit;
        out_set_q <= salt_pkg::SETOUT_W'(look_set);
        out_tag_q <= look_tag;
        out_way_q <= salt_pkg::WAYOUT_W'(sel.way);
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_hit_o          = out_hit_q;
  assign out_out_of_range_o = out_oor_q;
  assign out_set_index_o    = out_set_q;
  assign out_tag_value_o    = out_tag_q;
  assign out_way_used_o     = out_way_q;
  assign out_hit_total_o    = hit_cnt_q;
  assign out_access_total_o = acc_cnt_q;

  // Checks
  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == salt_pkg::ST_LOOK))
    else $error("accepted beat did not start a lookup");

  a_write_in_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == salt_pkg::ST_LOOK) && !oor))
    else $error("set write outside an in-range lookup");

  a_done_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    look_done |=> out_valid_q)
    else $error("finished lookup left no result");

  a_hits_le_accesses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_cnt_q <= acc_cnt_q)
    else $error("hit count above access count");

  a_oor_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_oor_q) |-> !out_hit_q)
    else $error("out-of-range result flagged as hit");

endmodule

`default_nettype wire
